/* rtl/core/pwag_pkg.sv */
package pwag_pkg;

    localparam int COEF_W = 32;
    localparam int N_REGS = 8;
    localparam int IDX_W  = 3;
    localparam int COL_W  = 8;
    localparam int ROW_W  = 9;
    // U, V, W sums: magnitude below 2^42, one spare bit for negation
    localparam int ACC_W  = 44;
    localparam int SRC_COL_W = 11;
    localparam int SRC_ROW_W = 9;
    localparam int ADDR_W    = 19;

    localparam logic signed [COEF_W-1:0] ONE_Q16 = 32'sd65536;

    localparam logic [IDX_W-1:0] REG_U_COL   = 3'd0;
    localparam logic [IDX_W-1:0] REG_U_ROW   = 3'd1;
    localparam logic [IDX_W-1:0] REG_U_CONST = 3'd2;
    localparam logic [IDX_W-1:0] REG_V_COL   = 3'd3;
    localparam logic [IDX_W-1:0] REG_V_ROW   = 3'd4;
    localparam logic [IDX_W-1:0] REG_V_CONST = 3'd5;
    localparam logic [IDX_W-1:0] REG_W_COL   = 3'd6;
    localparam logic [IDX_W-1:0] REG_W_ROW   = 3'd7;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t [N_REGS-1:0] coef_arr_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } side_t;

endpackage

/* rtl/core/pwag_affine.sv */
// Two stages: six products, then the three affine sums.
module pwag_affine
(
    input  logic                clk,
    input  logic                rst_n,
    input  pwag_pkg::coef_arr_t coef,
    input  pwag_pkg::side_t     side_in,
    output pwag_pkg::side_t     side_out,
    output pwag_pkg::acc_t      sum_u,
    output pwag_pkg::acc_t      sum_v,
    output pwag_pkg::acc_t      sum_w
);

    pwag_pkg::side_t side1_reg;
    pwag_pkg::side_t side2_reg;
    pwag_pkg::acc_t  p_uc_reg, p_ur_reg, p_vc_reg, p_vr_reg, p_wc_reg, p_wr_reg;
    pwag_pkg::acc_t  u_reg, v_reg, w_reg;

    logic signed [pwag_pkg::COL_W:0] col_s;
    logic signed [pwag_pkg::ROW_W:0] row_s;
    pwag_pkg::acc_t                  col_x;
    pwag_pkg::acc_t                  row_x;

    assign col_s = $signed({1'b0, side_in.col});
    assign row_s = $signed({1'b0, side_in.row});
    assign col_x = pwag_pkg::ACC_W'(col_s);
    assign row_x = pwag_pkg::ACC_W'(row_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            side2_reg <= '0;
        end
        else
        begin
            side1_reg <= side_in;
            side2_reg <= side1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_uc_reg <= pwag_pkg::ACC_W'(coef[pwag_pkg::REG_U_COL]) * col_x;
        p_ur_reg <= pwag_pkg::ACC_W'(coef[pwag_pkg::REG_U_ROW]) * row_x;
        p_vc_reg <= pwag_pkg::ACC_W'(coef[pwag_pkg::REG_V_COL]) * col_x;
        p_vr_reg <= pwag_pkg::ACC_W'(coef[pwag_pkg::REG_V_ROW]) * row_x;
        p_wc_reg <= pwag_pkg::ACC_W'(coef[pwag_pkg::REG_W_COL]) * col_x;
        p_wr_reg <= pwag_pkg::ACC_W'(coef[pwag_pkg::REG_W_ROW]) * row_x;
        u_reg <= p_uc_reg + p_ur_reg + pwag_pkg::ACC_W'(coef[pwag_pkg::REG_U_CONST]);
        v_reg <= p_vc_reg + p_vr_reg + pwag_pkg::ACC_W'(coef[pwag_pkg::REG_V_CONST]);
        w_reg <= p_wc_reg + p_wr_reg + pwag_pkg::ACC_W'(pwag_pkg::ONE_Q16);
    end

    assign side_out = side2_reg;
    assign sum_u    = u_reg;
    assign sum_v    = v_reg;
    assign sum_w    = w_reg;

endmodule

/* rtl/core/pwag_div_step.sv */
// One restoring division step: one quotient bit, weight 2^SHIFT.
module pwag_div_step
#(
    parameter int NW    = 44,
    parameter int QW    = 14,
    parameter int SHIFT = 0
)
(
    input  logic          clk,
    input  logic [NW-1:0] rem_in,
    input  logic [NW-1:0] den,
    input  logic [QW-1:0] q_in,
    output logic [QW-1:0] q_out,
    output logic [NW-1:0] rem_out
);

    logic [NW+QW-1:0] den_sh;
    logic [NW+QW-1:0] rem_ext;
    logic             take;
    logic [NW-1:0]    rem_next;
    logic [QW-1:0]    q_next;
    logic [NW-1:0]    rem_reg;
    logic [QW-1:0]    q_reg;

    always_comb
    begin
        den_sh   = {{QW{1'b0}}, den} << SHIFT;
        rem_ext  = {{QW{1'b0}}, rem_in};
        take     = rem_ext >= den_sh;
        rem_next = take ? NW'(rem_ext - den_sh) : rem_in;
        q_next   = q_in | (QW'(take) << SHIFT);
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

/* rtl/core/perspective_warp_address_generator_unit.sv */
// Channel  | Ports                                         | Transaction
// ---------+-----------------------------------------------+--------------------------
// item in  | start, busy, cell_col, cell_row               | start & !busy at clk edge
// result   | done, out_cell_col, out_cell_row, valid_res,  | done high for one cycle
//          | src_col, src_row, src_address                 |
// config   | cfg_we, cfg_addr, cfg_data                    | cfg_we at clk edge
//
// One cell enters per cycle; busy is never raised. Each cell passes in order
// through the affine products and sums, sign normalisation, the limit
// products, one restoring divider step per quotient bit (QW bits) and the
// output register. Reset (rst_n, async, active low) clears the valid bits
// and loads the identity coefficients; the result side has no back-pressure,
// so no stalls.
module perspective_warp_address_generator_unit
#(
    parameter int BEV_COLS     = 200,
    parameter int BEV_ROWS     = 400,
    parameter int IMAGE_WIDTH  = 1242,
    parameter int IMAGE_HEIGHT = 375
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pwag_pkg::COL_W-1:0]        cell_col,
    input  logic [pwag_pkg::ROW_W-1:0]        cell_row,
    input  logic                              cfg_we,
    input  logic [pwag_pkg::IDX_W-1:0]        cfg_addr,
    input  logic [pwag_pkg::COEF_W-1:0]       cfg_data,
    output logic                              done,
    output logic [pwag_pkg::COL_W-1:0]        out_cell_col,
    output logic [pwag_pkg::ROW_W-1:0]        out_cell_row,
    output logic                              valid_res,
    output logic [pwag_pkg::SRC_COL_W-1:0]    src_col,
    output logic [pwag_pkg::SRC_ROW_W-1:0]    src_row,
    output logic [pwag_pkg::ADDR_W-1:0]       src_address
);

    localparam int LIM_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    // quotient bits: a valid quotient never exceeds its limit
    localparam int QW = $clog2(LIM_MAX + 1);
    localparam int NW = pwag_pkg::ACC_W;
    localparam int LW = NW + QW;
    localparam int XW = 2 * QW + 20;
    localparam logic [LW-1:0] LIM_U = LW'(IMAGE_WIDTH);
    localparam logic [LW-1:0] LIM_V = LW'(IMAGE_HEIGHT);
    localparam logic [XW-1:0] ROW_PITCH = XW'(IMAGE_WIDTH);
    // identity mapping
    localparam pwag_pkg::coef_arr_t COEF_RESET = '{
        pwag_pkg::REG_U_COL: pwag_pkg::ONE_Q16,
        pwag_pkg::REG_V_ROW: pwag_pkg::ONE_Q16,
        default:             '0
    };

    assign busy = 1'b0;

    // ---------------- coefficient registers
    pwag_pkg::coef_arr_t coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_addr] <= cfg_data;
        end
    end

    // ---------------- stages 1-2: U, V, W
    pwag_pkg::side_t side_in;
    pwag_pkg::side_t side_aff;
    pwag_pkg::acc_t  sum_u, sum_v, sum_w;

    assign side_in = '{valid: start, col: cell_col, row: cell_row};

    pwag_affine u_affine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef     (coef_reg),
        .side_in  (side_in),
        .side_out (side_aff),
        .sum_u    (sum_u),
        .sum_v    (sum_v),
        .sum_w    (sum_w)
    );

    // ---------------- stage 3: make the denominator non-negative
    pwag_pkg::side_t side3_reg;
    pwag_pkg::acc_t  nu3_reg, nv3_reg, d3_reg;
    pwag_pkg::acc_t  nu3_next, nv3_next, d3_next;

    always_comb
    begin
        if (sum_w < 0)
        begin
            nu3_next = -sum_u;
            nv3_next = -sum_v;
            d3_next  = -sum_w;
        end
        else
        begin
            nu3_next = sum_u;
            nv3_next = sum_v;
            d3_next  = sum_w;
        end
    end

    // ---------------- stage 4: limit products, cell range, zero-denominator and lower bound checks
    pwag_pkg::side_t side4_reg;
    pwag_pkg::acc_t  nu4_reg, nv4_reg, d4_reg;
    logic [LW-1:0]   lim_u4_reg, lim_v4_reg;
    logic            ok4_reg, ok4_next;
    logic            cell_ok;

    always_comb
    begin
        cell_ok  = (int'(side3_reg.col) < BEV_COLS) && (int'(side3_reg.row) < BEV_ROWS);
        ok4_next = cell_ok && (d3_reg != '0) && (nu3_reg >= d3_reg) && (nv3_reg >= d3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side3_reg <= '0;
            side4_reg <= '0;
        end
        else
        begin
            side3_reg <= side_aff;
            side4_reg <= side3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nu3_reg    <= nu3_next;
        nv3_reg    <= nv3_next;
        d3_reg     <= d3_next;
        nu4_reg    <= nu3_reg;
        nv4_reg    <= nv3_reg;
        d4_reg     <= d3_reg;
        ok4_reg    <= ok4_next;
        lim_u4_reg <= LW'({{QW{1'b0}}, d3_reg} * LIM_U);
        lim_v4_reg <= LW'({{QW{1'b0}}, d3_reg} * LIM_V);
    end

    // ---------------- divider chain, MSB first
    pwag_pkg::side_t side_d [QW+1];
    logic            ok_d   [QW+1];
    logic [NW-1:0]   den_d  [QW+1];
    logic [NW-1:0]   rem_u  [QW+1];
    logic [NW-1:0]   rem_v  [QW+1];
    logic [QW-1:0]   q_u    [QW+1];
    logic [QW-1:0]   q_v    [QW+1];

    // upper bound checks fold into the first step's flag
    assign side_d[0] = side4_reg;
    assign ok_d[0]   = ok4_reg
                       && ({{QW{1'b0}}, nu4_reg} <= lim_u4_reg)
                       && ({{QW{1'b0}}, nv4_reg} <= lim_v4_reg);
    assign den_d[0]  = d4_reg;
    assign rem_u[0]  = nu4_reg;
    assign rem_v[0]  = nv4_reg;
    assign q_u[0]    = '0;
    assign q_v[0]    = '0;

    genvar g;
    generate
        for (g = 0; g < QW; g++)
        begin : g_div
            pwag_pkg::side_t side_reg;
            logic            ok_reg;
            logic [NW-1:0]   den_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg <= '0;
                end
                else
                begin
                    side_reg <= side_d[g];
                end
            end

            always_ff @(posedge clk)
            begin
                ok_reg  <= ok_d[g];
                den_reg <= den_d[g];
            end

            assign side_d[g+1] = side_reg;
            assign ok_d[g+1]   = ok_reg;
            assign den_d[g+1]  = den_reg;

            pwag_div_step #(.NW(NW), .QW(QW), .SHIFT(QW - 1 - g)) u_step_u
            (
                .clk     (clk),
                .rem_in  (rem_u[g]),
                .den     (den_d[g]),
                .q_in    (q_u[g]),
                .q_out   (q_u[g+1]),
                .rem_out (rem_u[g+1])
            );

            pwag_div_step #(.NW(NW), .QW(QW), .SHIFT(QW - 1 - g)) u_step_v
            (
                .clk     (clk),
                .rem_in  (rem_v[g]),
                .den     (den_d[g]),
                .q_in    (q_v[g]),
                .q_out   (q_v[g+1]),
                .rem_out (rem_v[g+1])
            );
        end
    endgenerate

    // ---------------- output stage: zero-based pixel and linear address
    logic [XW-1:0] sc_next, sr_next, addr_next;
    logic          ok_f;

    always_comb
    begin
        ok_f = ok_d[QW];
        if (ok_f)
        begin
            sc_next = XW'(q_u[QW]) - XW'(1);
            sr_next = XW'(q_v[QW]) - XW'(1);
        end
        else
        begin
            sc_next = '0;
            sr_next = '0;
        end
        addr_next = XW'(sr_next * ROW_PITCH) + sc_next;
    end

    logic                           done_reg;
    logic [pwag_pkg::COL_W-1:0]     col_o_reg;
    logic [pwag_pkg::ROW_W-1:0]     row_o_reg;
    logic                           ok_o_reg;
    logic [pwag_pkg::SRC_COL_W-1:0] sc_reg;
    logic [pwag_pkg::SRC_ROW_W-1:0] sr_reg;
    logic [pwag_pkg::ADDR_W-1:0]    addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= side_d[QW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        col_o_reg <= side_d[QW].col;
        row_o_reg <= side_d[QW].row;
        ok_o_reg  <= ok_f;
        sc_reg    <= sc_next[pwag_pkg::SRC_COL_W-1:0];
        sr_reg    <= sr_next[pwag_pkg::SRC_ROW_W-1:0];
        addr_reg  <= addr_next[pwag_pkg::ADDR_W-1:0];
    end

    assign done         = done_reg;
    assign out_cell_col = col_o_reg;
    assign out_cell_row = row_o_reg;
    assign valid_res    = ok_o_reg;
    assign src_col      = sc_reg;
    assign src_row      = sr_reg;
    assign src_address  = addr_reg;

endmodule
